/* design/ctw_pkg.sv */
// shared types, codes and sizes for the connection timing wheel
package ctw_pkg;

  // wheel and table sizes
  localparam int WHEEL_SLOTS     = 64;
  localparam int MAX_CONNECTIONS = 64;

  // derived widths
  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 6;
  localparam int TIMEOUT_W = 8;
  localparam int STATUS_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK              = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT_LARGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_TRACKED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_TRACKED = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FLUSH
  } ctw_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic idle;
    logic accept;
    logic exec;
    logic scan_take;
    logic scan_step;
    logic flush;
  } ctw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_tick;
    logic out_free;
    logic hit;
    logic scan_end;
    logic pend_valid;
  } ctw_stat_t;

endpackage

/* design/ctw_ctrl.sv */
// controller state machine for the connection timing wheel
module ctw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ctw_pkg::ctw_stat_t stat,
  output ctw_pkg::ctw_cmd_t  cmd
);

  ctw_pkg::ctw_state_t state;
  ctw_pkg::ctw_state_t state_next;
  logic                hold;

  // a hit must wait while the previous expired id cannot be pushed
  assign hold = stat.hit && stat.pend_valid && !stat.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_tick ? ctw_pkg::S_SCAN_RD : ctw_pkg::S_CMD;
        end
      end
      ctw_pkg::S_CMD: begin
        if (stat.out_free) begin
          state_next = ctw_pkg::S_IDLE;
        end
      end
      ctw_pkg::S_SCAN_RD: begin
        state_next = ctw_pkg::S_SCAN_CMP;
      end
      ctw_pkg::S_SCAN_CMP: begin
        if (!hold) begin
          state_next = stat.scan_end ? ctw_pkg::S_FLUSH : ctw_pkg::S_SCAN_RD;
        end
      end
      ctw_pkg::S_FLUSH: begin
        if (stat.out_free) begin
          state_next = ctw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ctw_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ctw_pkg::S_IDLE: begin
        cmd.idle   = 1'b1;
        cmd.accept = in_valid;
      end
      ctw_pkg::S_CMD: begin
        cmd.exec = stat.out_free;
      end
      ctw_pkg::S_SCAN_RD: begin
        cmd = '0;
      end
      ctw_pkg::S_SCAN_CMP: begin
        cmd.scan_take = stat.hit && !hold;
        cmd.scan_step = !hold && !stat.scan_end;
      end
      ctw_pkg::S_FLUSH: begin
        cmd.flush = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/ctw_datapath.sv */
// slot memory, tracked flags, scan counter and result register
module ctw_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ctw_pkg::ctw_cmd_t               cmd,
  output ctw_pkg::ctw_stat_t              stat,
  input  logic [ctw_pkg::CMD_W-1:0]       command,
  input  logic [ctw_pkg::ID_W-1:0]        conn_id,
  input  logic [ctw_pkg::TIMEOUT_W-1:0]   timeout,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [ctw_pkg::STATUS_W-1:0]    status,
  output logic                            expired_valid,
  output logic [ctw_pkg::ID_W-1:0]        expired_id,
  output logic                            last
);

  localparam int SLOTS = ctw_pkg::WHEEL_SLOTS;
  localparam int CONNS = ctw_pkg::MAX_CONNECTIONS;
  localparam int SW    = ctw_pkg::SLOT_W;
  localparam int IW    = ctw_pkg::IDX_W;

  // slot memory, undefined until written
  logic [SW-1:0] slot_mem [CONNS];
  logic [SW-1:0] rd_slot;

  // tracked flags and wheel pointer
  logic [CONNS-1:0] tracked;
  logic [SW-1:0]    current_slot;

  // latched input beat
  logic [ctw_pkg::CMD_W-1:0]     cmd_q;
  logic [ctw_pkg::ID_W-1:0]      id_q;
  logic [ctw_pkg::TIMEOUT_W-1:0] timeout_q;

  // scan state
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] pend_id;
  logic          pend_valid;

  // command decode
  logic          in_table;
  logic          too_large;
  logic          is_tracked;
  logic [IW-1:0] id_idx;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] target_slot;
  logic [ctw_pkg::STATUS_W-1:0] cmd_status;
  logic          do_write;
  logic          do_set;
  logic          do_clear;

  // result push
  logic                         out_free;
  logic                         push;
  logic [ctw_pkg::STATUS_W-1:0] push_status;
  logic                         push_valid;
  logic [ctw_pkg::ID_W-1:0]     push_id;
  logic                         push_last;

  // id range, timeout range and target slot
  assign id_idx      = id_q[IW-1:0];
  assign in_table    = (7'(id_q) < 7'(CONNS));
  assign too_large   = (9'(timeout_q) >= 9'(SLOTS));
  assign is_tracked  = in_table && tracked[id_idx];
  assign slot_sum    = (SW+1)'(current_slot) + (SW+1)'(timeout_q[SW-1:0]);
  assign target_slot = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                                     : slot_sum[SW-1:0];

  // status and table effect of add, update and remove
  always_comb begin
    cmd_status = ctw_pkg::ST_OK;
    do_write   = 1'b0;
    do_set     = 1'b0;
    do_clear   = 1'b0;
    case (cmd_q)
      ctw_pkg::CMD_ADD: begin
        if (too_large) begin
          cmd_status = ctw_pkg::ST_TIMEOUT_LARGE;
        end else if (!in_table) begin
          cmd_status = ctw_pkg::ST_NOT_TRACKED;
        end else if (is_tracked) begin
          cmd_status = ctw_pkg::ST_ALREADY_TRACKED;
        end else begin
          do_write = 1'b1;
          do_set   = 1'b1;
        end
      end
      ctw_pkg::CMD_UPDATE: begin
        if (!is_tracked) begin
          cmd_status = ctw_pkg::ST_NOT_TRACKED;
        end else if (too_large) begin
          cmd_status = ctw_pkg::ST_TIMEOUT_LARGE;
        end else begin
          do_write = 1'b1;
        end
      end
      ctw_pkg::CMD_REMOVE: begin
        if (!is_tracked) begin
          cmd_status = ctw_pkg::ST_NOT_TRACKED;
        end else begin
          do_clear = 1'b1;
        end
      end
      default: begin
        cmd_status = ctw_pkg::ST_OK;
      end
    endcase
  end

  // slot memory: written by commands, read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      slot_mem[id_idx] <= target_slot;
    end
    rd_slot <= slot_mem[scan_idx];
  end

  // status toward the controller
  assign out_free = !out_valid || !out_stall;
  always_comb begin
    stat.in_tick    = (command == ctw_pkg::CMD_TICK);
    stat.out_free   = out_free;
    stat.hit        = tracked[scan_idx] && (rd_slot == current_slot);
    stat.scan_end   = (scan_idx == IW'(CONNS - 1));
    stat.pend_valid = pend_valid;
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q     <= command;
      id_q      <= conn_id;
      timeout_q <= timeout;
    end
  end

  // tracked flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked <= '0;
    end else if (cmd.exec && do_set) begin
      tracked[id_idx] <= 1'b1;
    end else if (cmd.exec && do_clear) begin
      tracked[id_idx] <= 1'b0;
    end else if (cmd.scan_take) begin
      tracked[scan_idx] <= 1'b0;
    end
  end

  // scan counter, held expired id and wheel pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx     <= '0;
      pend_valid   <= 1'b0;
      current_slot <= '0;
    end else begin
      if (cmd.accept) begin
        scan_idx   <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.scan_take) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (cmd.flush) begin
        current_slot <= (current_slot == SW'(SLOTS - 1)) ? '0 : current_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_take) begin
      pend_id <= scan_idx;
    end
  end

  // result beat selection
  always_comb begin
    push        = 1'b0;
    push_status = ctw_pkg::ST_OK;
    push_valid  = 1'b0;
    push_id     = '0;
    push_last   = 1'b1;
    if (cmd.exec) begin
      push        = 1'b1;
      push_status = cmd_status;
    end else if (cmd.scan_take && pend_valid) begin
      push       = 1'b1;
      push_valid = 1'b1;
      push_id    = ctw_pkg::ID_W'(pend_id);
      push_last  = 1'b0;
    end else if (cmd.flush) begin
      push       = 1'b1;
      push_valid = pend_valid;
      push_id    = pend_valid ? ctw_pkg::ID_W'(pend_id) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status        <= push_status;
      expired_valid <= push_valid;
      expired_id    <= push_id;
      last          <= push_last;
    end
  end

endmodule

/* design/connection_timing_wheel.sv */
// connection timing wheel: add, update and remove commands are latched on accept and executed
// once the output register is free; a tick scans the whole id table, waiting on output stalls
// the scan takes one registered read of the slot memory per id and a compare
// one item in flight at a time; the next beat is taken once the last result is registered
// reset clears tracked flags, the wheel pointer, the controller and the output valid
module connection_timing_wheel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctw_pkg::CMD_W-1:0]     command,
  input  logic [ctw_pkg::ID_W-1:0]      conn_id,
  input  logic [ctw_pkg::TIMEOUT_W-1:0] timeout,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ctw_pkg::STATUS_W-1:0]  status,
  output logic                          expired_valid,
  output logic [ctw_pkg::ID_W-1:0]      expired_id,
  output logic                          last
);

  ctw_pkg::ctw_cmd_t  ctl_cmd;
  ctw_pkg::ctw_stat_t dp_stat;

  // controller
  ctw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  // datapath
  ctw_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl_cmd),
    .stat          (dp_stat),
    .command       (command),
    .conn_id       (conn_id),
    .timeout       (timeout),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .expired_valid (expired_valid),
    .expired_id    (expired_id),
    .last          (last)
  );

  // input beats only while the controller is idle
  assign in_stall = !ctl_cmd.idle;

  // a result without an expired id always closes its item
  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !expired_valid |-> last)
    else $error("result without expired id not marked last");

  // expired ids always report ok status
  a_expired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && expired_valid |-> status == ctw_pkg::ST_OK)
    else $error("expired id with nonzero status");

  // pushing a held id only happens when the output register can take it
  a_take_push_free: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.scan_take && dp_stat.pend_valid |-> dp_stat.out_free)
    else $error("expired id pushed into a full output register");

  // a final result pushed by a command or a flush is visible in the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.exec || ctl_cmd.flush |=> out_valid && last)
    else $error("final result of an item not registered");

endmodule
